>>> src/drill_leadscrew_sequencer_defines.svh
// ----------------------------------------------------------------------------
// drill lead screw sequencer assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef DRILL_LEADSCREW_SEQUENCER_DEFINES_SVH
`define DRILL_LEADSCREW_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// implication or plain property, checked on every clock edge outside reset
`define DLS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("dls assertion failed");

// condition that must never be seen outside reset
`define DLS_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("dls forbidden condition seen");

`else

`define DLS_ASSERT(name, clk, rst_n, prop)
`define DLS_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

>>> src/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// types and constants shared by the drill lead screw sequencer
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int unsigned DWELL_W   = 17;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = DWELL_W;

  localparam logic [DWELL_W-1:0] DWELL_RESET = DWELL_W'(30000);
  localparam logic [DUTY_W-1:0]  DUTY_RESET  = DUTY_W'(1);
  localparam logic [DWELL_W-1:0] TIMER_MAX   = '1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DWELL_MS   = 2'd0,
    CFG_SCREW_DUTY = 2'd1
  } dls_cfg_idx_e;

  // lead screw command
  typedef enum logic [1:0] {
    DRIVE_COAST = 2'd0,
    DRIVE_UP    = 2'd1,
    DRIVE_DOWN  = 2'd2
  } dls_drive_e;

  typedef struct packed {
    logic                 upper_switch;
    logic                 lower_switch;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } dls_in_t;

  typedef struct packed {
    logic [1:0]        screw_drive;
    logic [DUTY_W-1:0] drive_duty;
    logic              auger_on;
    logic              top_count;
    logic              bottom_count;
    logic              dwelling;
    logic              retracting;
    logic              cycle_done;
  } dls_out_t;

  // sequencer state carried between ticks
  typedef struct packed {
    logic               prev_upper;
    logic               prev_lower;
    logic               top_hit;
    logic               bottom_hit;
    logic               moving_up;
    logic               fully_extended;
    logic               dwell_active;
    logic               dwell_finished;
    logic [DWELL_W-1:0] dwell_timer;
    dls_drive_e         screw_command;
    logic               auger_state;
  } dls_state_t;

endpackage

>>> src/dls_step.sv
// ----------------------------------------------------------------------------
// dls_step
// next-state and result logic for one control tick
// ----------------------------------------------------------------------------
module dls_step (
  input  dls_pkg::dls_state_t              state_i,
  input  dls_pkg::dls_in_t                 in_i,
  input  logic [dls_pkg::DWELL_W-1:0]      dwell_ms_i,
  input  logic [dls_pkg::DUTY_W-1:0]       screw_duty_i,
  output dls_pkg::dls_state_t              state_o,
  output dls_pkg::dls_out_t                result_o
);
  import dls_pkg::*;

  localparam logic [1:0] HITS_NONE  = 2'd0;
  localparam logic [1:0] HITS_ONCE  = 2'd1;
  localparam logic [1:0] HITS_TWICE = 2'd2;

  dls_state_t         st;
  logic [DWELL_W:0]   timer_sum;
  logic [1:0]         top_hits;
  logic               rise_u;
  logic               rise_l;
  logic               done;

  always_comb begin
    st        = state_i;
    top_hits  = {1'b0, state_i.top_hit};
    done      = 1'b0;

    // saturating dwell timer
    timer_sum = {1'b0, state_i.dwell_timer} + (DWELL_W+1)'(in_i.elapsed_ms);
    st.dwell_timer = timer_sum[DWELL_W] ? TIMER_MAX : timer_sum[DWELL_W-1:0];

    rise_u = in_i.upper_switch & ~state_i.prev_upper;
    rise_l = in_i.lower_switch & ~state_i.prev_lower;
    st.prev_upper = in_i.upper_switch;
    st.prev_lower = in_i.lower_switch;

    if (rise_u && top_hits == HITS_NONE) begin
      st.screw_command = DRIVE_COAST;
      top_hits         = HITS_ONCE;
    end
    if (top_hits == HITS_NONE) begin
      st.screw_command = DRIVE_UP;
    end
    if (!st.bottom_hit && top_hits == HITS_ONCE) begin
      st.auger_state   = 1'b1;
      st.screw_command = DRIVE_DOWN;
      st.moving_up     = 1'b0;
    end
    if (!st.moving_up && !st.bottom_hit && rise_l) begin
      st.bottom_hit = 1'b1;
    end
    if (st.bottom_hit && top_hits == HITS_ONCE && !st.dwell_finished &&
        !st.dwell_active) begin
      st.screw_command  = DRIVE_COAST;
      st.fully_extended = 1'b1;
      st.dwell_active   = 1'b1;
      st.dwell_timer    = '0;
    end
    if (st.fully_extended && st.bottom_hit && top_hits == HITS_ONCE &&
        st.dwell_active && st.dwell_timer >= dwell_ms_i) begin
      st.dwell_active   = 1'b0;
      st.fully_extended = 1'b0;
      st.dwell_finished = 1'b1;
      st.screw_command  = DRIVE_UP;
      st.moving_up      = 1'b1;
    end
    if (st.moving_up && rise_u && st.bottom_hit && top_hits == HITS_ONCE) begin
      st.screw_command = DRIVE_COAST;
      st.moving_up     = 1'b0;
      top_hits         = HITS_TWICE;
    end
    // cycle end: clear counters and edge history
    if (top_hits == HITS_TWICE && st.bottom_hit) begin
      st.prev_upper     = 1'b0;
      st.prev_lower     = 1'b0;
      st.dwell_finished = 1'b0;
      top_hits          = HITS_NONE;
      st.bottom_hit     = 1'b0;
      st.fully_extended = 1'b0;
      st.dwell_active   = 1'b0;
      done              = 1'b1;
    end
    st.top_hit = top_hits[0];
  end

  assign state_o = st;

  always_comb begin
    result_o.screw_drive  = st.screw_command;
    result_o.drive_duty   = (st.screw_command != DRIVE_COAST) ? screw_duty_i : '0;
    result_o.auger_on     = st.auger_state;
    result_o.top_count    = st.top_hit;
    result_o.bottom_count = st.bottom_hit;
    result_o.dwelling     = st.dwell_active;
    result_o.retracting   = st.moving_up;
    result_o.cycle_done   = done;
  end

endmodule

>>> src/drill_leadscrew_sequencer.sv
// ----------------------------------------------------------------------------
// drill_leadscrew_sequencer
// lead screw and auger sequencer driven by limit switch ticks
// ----------------------------------------------------------------------------
// Each input transfer is one control tick carrying the two limit switch levels
// and the milliseconds since the previous tick; each tick yields exactly one
// result transfer. Rising switch edges step a fixed drilling cycle: raise the
// screw to the top switch, start the auger and lower to the bottom switch,
// coast for dwell_ms while the auger spins, raise to the top switch again,
// then clear the counters and report cycle_done. The whole tick update is a
// single pass of shallow logic from the state register into the result
// register, so a new tick is taken every cycle as long as the result register
// is empty or is being read in the same cycle. Configuration writes are always
// taken, index 0 sets dwell_ms, index 1 sets screw_duty, other indexes are
// ignored; write only while idle.
module drill_leadscrew_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tick input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dls_pkg::dls_in_t                  in_data_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dls_pkg::dls_out_t                 out_data_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dls_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [dls_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import dls_pkg::*;

`include "drill_leadscrew_sequencer_defines.svh"

  // configuration registers
  logic [DWELL_W-1:0] dwell_ms_q;
  logic [DUTY_W-1:0]  screw_duty_q;

  // sequencer state and result register
  dls_state_t state_q, state_d;
  dls_out_t   result_d, out_data_q;
  logic       out_valid_q;

  logic in_xfer;
  logic cfg_xfer;

  // result register frees up when empty or drained this cycle
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_xfer     = in_valid_i & in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i;

  dls_step u_step (
    .state_i      (state_q),
    .in_i         (in_data_i),
    .dwell_ms_i   (dwell_ms_q),
    .screw_duty_i (screw_duty_q),
    .state_o      (state_d),
    .result_o     (result_d)
  );

  // configuration write, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dwell_ms_q   <= DWELL_RESET;
      screw_duty_q <= DUTY_RESET;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        CFG_DWELL_MS:   dwell_ms_q   <= cfg_data_i;
        CFG_SCREW_DUTY: screw_duty_q <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // state advances only on an accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // every accepted tick shows up as a result in the next cycle
  `DLS_ASSERT(a_tick_gives_result, clk_i, rst_ni, in_xfer |=> out_valid_q)
  // the auger is never switched off once started
  `DLS_ASSERT(a_auger_stays_on, clk_i, rst_ni, state_q.auger_state |=> state_q.auger_state)
  // dwelling and retracting exclude each other
  `DLS_ASSERT_NEVER(a_dwell_vs_retract, clk_i, rst_ni,
                    state_q.dwell_active && state_q.moving_up)
  // a finished cycle always reports cleared counters
  `DLS_ASSERT_NEVER(a_done_counters_clear, clk_i, rst_ni,
                    out_valid_q && out_data_q.cycle_done &&
                    (out_data_q.top_count || out_data_q.bottom_count))

endmodule
